[src/fconv_pkg.sv]
// ============================================================================
// fconv_pkg
// Shared widths, register indexes and types for the transposed-form FIR
// convolution block.
// ============================================================================
package fconv_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int SUM_W       = 35;
    localparam int VALUE_W     = 34;
    localparam int TAP_CNT_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Default filter length supported by the hardware.
    localparam int DEFAULT_MAX_TAPS = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam int                   REG_COEF_BASE = 1;

    // Status of the output queue as seen by the pipeline.
    typedef struct packed {
        logic has_word;
        logic can_load;
    } fconv_oq_status_t;

endpackage

[src/fconv_out_queue.sv]
// ============================================================================
// fconv_out_queue
// Output queue holding up to MAX_TAPS result words. A normal sample loads a
// single word; an end-of-sequence sample loads the whole tail in one go.
// ============================================================================
module fconv_out_queue #(
    parameter int MAX_TAPS = fconv_pkg::DEFAULT_MAX_TAPS,
    localparam int CNT_W   = $clog2(MAX_TAPS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [CNT_W-1:0]             load_cnt,
    input  logic [fconv_pkg::VALUE_W-1:0] load_val [MAX_TAPS],
    input  logic                         load_fin [MAX_TAPS],
    input  logic                         out_stall,
    output fconv_pkg::fconv_oq_status_t  status,
    output logic [fconv_pkg::VALUE_W-1:0] value,
    output logic                         final_output
);

    logic [fconv_pkg::VALUE_W-1:0] val_reg [MAX_TAPS];
    logic                          fin_reg [MAX_TAPS];
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          drain;

    // The head word leaves whenever the receiver does not stall.
    assign drain           = (cnt_reg != '0) && !out_stall;
    assign status.has_word = (cnt_reg != '0);
    assign status.can_load = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && drain);

    assign value        = val_reg[0];
    assign final_output = fin_reg[0];

    // Word count: a load replaces whatever has just drained.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = load_cnt;
        end
        else if (drain)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload words shift towards the head as they drain.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                val_reg[i] <= load_val[i];
                fin_reg[i] <= load_fin[i];
            end
        end
        else if (drain)
        begin
            for (int i = 0; i < MAX_TAPS - 1; i++)
            begin
                val_reg[i] <= val_reg[i + 1];
                fin_reg[i] <= fin_reg[i + 1];
            end
        end
    end

endmodule

[src/fir_convolution_1d.sv]
// ============================================================================
// fir_convolution_1d
// Full linear convolution of a sample sequence with up to MAX_TAPS taps,
// computed in transposed form.
// ============================================================================
// Usage:
// Samples enter on the input channel (in_valid, in_stall, sample,
// end_of_sequence) and results leave on the output channel (out_valid,
// out_stall, value, final_output). A word is taken at a clock edge where
// valid is high and stall is low. Coefficients and the tap count are written
// through the configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) while the block is idle; cfg_ready is always high.
// A result passes through an input register, a product register and the
// output queue, each of which holds it while the next stage is full.
// Throughput: one sample per cycle while out_stall is low. An end-of-sequence
// sample produces tap_count words, which leave through the single output port
// at one word per cycle, so the input holds off after it while they drain.
// Reset clears the pipeline, the partial sums and the output queue, sets
// tap_count to one and every coefficient to zero.
// When the receiver stalls, the head word is held and the pipeline fills;
// in_stall rises once the input register can no longer move on.
// ============================================================================
module fir_convolution_1d #(
    parameter int MAX_TAPS = fconv_pkg::DEFAULT_MAX_TAPS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [fconv_pkg::SAMPLE_W-1:0] sample,
    input  logic                             end_of_sequence,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [fconv_pkg::VALUE_W-1:0]  value,
    output logic                             final_output,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fconv_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int PEND  = MAX_TAPS - 1;

    // Configuration registers.
    logic [fconv_pkg::TAP_CNT_W-1:0]     tap_count_reg;
    logic signed [fconv_pkg::COEF_W-1:0] coef_reg [MAX_TAPS];
    logic [CNT_W-1:0]                    tap_n;

    // Input register.
    logic                                  a_valid_reg;
    logic                                  a_valid_next;
    logic signed [fconv_pkg::SAMPLE_W-1:0] a_sample_reg;
    logic                                  a_eos_reg;

    // Product register.
    logic                                b_valid_reg;
    logic                                b_valid_next;
    logic signed [fconv_pkg::PROD_W-1:0] prod_reg  [MAX_TAPS];
    logic signed [fconv_pkg::PROD_W-1:0] prod_next [MAX_TAPS];
    logic                                b_eos_reg;
    logic [CNT_W-1:0]                    b_n_reg;

    // Row of pending partial sums.
    logic signed [fconv_pkg::SUM_W-1:0] ps_reg  [PEND];
    logic signed [fconv_pkg::SUM_W-1:0] ps_next [PEND];
    logic signed [fconv_pkg::SUM_W-1:0] ps_ext  [PEND + 1];
    logic signed [fconv_pkg::SUM_W-1:0] ps_new  [PEND];
    logic signed [fconv_pkg::SUM_W-1:0] current;

    // Handshake between stages.
    logic in_accept;
    logic a_move;
    logic b_ready;
    logic b_fire;

    // Output queue connections.
    fconv_pkg::fconv_oq_status_t   oq_status;
    logic [CNT_W-1:0]              load_cnt;
    logic [fconv_pkg::VALUE_W-1:0] load_val [MAX_TAPS];
    logic                          load_fin [MAX_TAPS];
    logic [fconv_pkg::VALUE_W-1:0] oq_value;

    assign cfg_ready = 1'b1;

    // Configuration writes; indexes past the last coefficient are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fconv_pkg::TAP_CNT_W'(1);
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fconv_pkg::REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[fconv_pkg::TAP_CNT_W-1:0];
            end
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                if (cfg_index == fconv_pkg::CFG_IDX_W'(fconv_pkg::REG_COEF_BASE + k))
                begin
                    coef_reg[k] <= cfg_data[fconv_pkg::COEF_W-1:0];
                end
            end
        end
    end

    // Active filter length: zero counts as one, larger values clamp.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            tap_n = CNT_W'(1);
        end
        else if (tap_count_reg > fconv_pkg::TAP_CNT_W'(MAX_TAPS))
        begin
            tap_n = CNT_W'(MAX_TAPS);
        end
        else
        begin
            tap_n = CNT_W'(tap_count_reg);
        end
    end

    // Stage handshakes.
    assign b_fire    = b_valid_reg && oq_status.can_load;
    assign b_ready   = !b_valid_reg || oq_status.can_load;
    assign a_move    = a_valid_reg && b_ready;
    assign in_stall  = a_valid_reg && !b_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_sample_reg <= sample;
            a_eos_reg    <= end_of_sequence;
        end
    end

    // One multiplier per tap; taps beyond the active length give zero.
    always_comb
    begin
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            if ((k == 0) || (CNT_W'(k) < tap_n))
            begin
                prod_next[k] = a_sample_reg * coef_reg[k];
            end
            else
            begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            b_eos_reg <= a_eos_reg;
            b_n_reg   <= tap_n;
        end
    end

    // Partial-sum update: each sum moves one place towards the output and
    // picks up its product; the oldest completes the current output.
    always_comb
    begin
        for (int k = 0; k < PEND; k++)
        begin
            ps_ext[k] = ps_reg[k];
        end
        ps_ext[PEND] = '0;
        current = ps_reg[0] + fconv_pkg::SUM_W'(prod_reg[0]);
        for (int k = 0; k < PEND; k++)
        begin
            ps_new[k] = ps_ext[k + 1] + fconv_pkg::SUM_W'(prod_reg[k + 1]);
        end
    end

    // At the end of a sequence the row is emptied for the next one.
    always_comb
    begin
        for (int k = 0; k < PEND; k++)
        begin
            if (b_eos_reg)
            begin
                ps_next[k] = '0;
            end
            else
            begin
                ps_next[k] = ps_new[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PEND; k++)
            begin
                ps_reg[k] <= '0;
            end
        end
        else if (b_fire)
        begin
            for (int k = 0; k < PEND; k++)
            begin
                ps_reg[k] <= ps_next[k];
            end
        end
    end

    // Result words: the current output, then the pending tails on a flush.
    always_comb
    begin
        load_val[0] = current[fconv_pkg::VALUE_W-1:0];
        load_fin[0] = b_eos_reg && (b_n_reg == CNT_W'(1));
        for (int j = 0; j < PEND; j++)
        begin
            load_val[j + 1] = ps_new[j][fconv_pkg::VALUE_W-1:0];
            load_fin[j + 1] = (b_n_reg == CNT_W'(j + 2));
        end
        if (b_eos_reg)
        begin
            load_cnt = b_n_reg;
        end
        else
        begin
            load_cnt = CNT_W'(1);
        end
    end

    fconv_out_queue #(
        .MAX_TAPS(MAX_TAPS)
    ) u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (b_fire),
        .load_cnt    (load_cnt),
        .load_val    (load_val),
        .load_fin    (load_fin),
        .out_stall   (out_stall),
        .status      (oq_status),
        .value       (oq_value),
        .final_output(final_output)
    );

    assign out_valid = oq_status.has_word;
    assign value     = oq_value;

endmodule

[src/fconv_checker.sv]
// ============================================================================
// fconv_checker
// Port-level checks for the FIR convolution block, bound to the top level.
// ============================================================================
module fconv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [fconv_pkg::VALUE_W-1:0]    value,
    input logic                             final_output,
    input logic                             cfg_ready
);

    // Nothing is offered on the output straight after reset.
    a_quiet_after_reset: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid
    ) else $error("output word offered straight after reset");

    // A stalled result word stays put.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value) && $stable(final_output))
    ) else $error("stalled output word changed");

    // With the output queue empty there is always room for a new sample.
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall
    ) else $error("input stalled while output queue is empty");

    // The configuration channel never holds off a write.
    a_cfg_open: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid || !in_valid |-> cfg_ready
    ) else $error("configuration channel not ready");

endmodule

bind fir_convolution_1d fconv_checker u_fconv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .final_output(final_output),
    .cfg_ready   (cfg_ready)
);
